/* design/olts_pkg.sv */
`default_nettype none
package olts_pkg;

  localparam int STAMP_W  = 48;
  localparam int ITER_W   = 32;
  localparam int PIECES_W = 16;
  localparam int WORD_W   = 32;
  localparam int IDX_W    = 10;

  typedef enum logic [1:0] {
    OP_APPEND    = 2'd0,
    OP_FIND_TIME = 2'd1,
    OP_FIND_ITER = 2'd2,
    OP_SKEW      = 2'd3
  } op_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_TSRCH  = 6'b000010,
    ST_ISRCH  = 6'b000100,
    ST_TFETCH = 6'b001000,
    ST_IFETCH = 6'b010000,
    ST_SKEW   = 6'b100000
  } state_t;

  // Everything of an entry except its time, which lives in a memory of its own.
  typedef struct packed {
    logic [ITER_W-1:0]   iteration;
    logic [PIECES_W-1:0] pieces;
    logic [WORD_W-1:0]   weight;
    logic [WORD_W-1:0]   payload;
    logic [WORD_W-1:0]   domain;
  } entry_t;

  typedef struct packed {
    logic                      ok;
    logic                      interior;
    logic [IDX_W-1:0]          idx;
    logic signed [STAMP_W-1:0] stamp;
    entry_t                    entry;
    logic                      full;
  } res_t;

endpackage
`default_nettype wire

/* design/olts_ram.sv */
`default_nettype none
module olts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/ordered_log_table_search.sv */
`default_nettype none
// Append-only log table with time and iteration lookup. A word is taken when
// start is high and busy is low; its result appears on the out_ ports for one
// cycle with out_valid high and cannot be held off by the receiver. Appends,
// refused appends, lookups and skews on an empty table, and iteration lookups
// outside the stored iteration range answer in the cycle after start and never
// raise busy. A time lookup at or beyond either end goes straight to the fetch
// state; one strictly inside runs a binary search first when more than two
// entries are stored, as does every other iteration lookup, one search step per
// cycle, bounded by the single read port of the entry memories. A skew walks
// the stored times through a read-modify-write pipeline, one entry per cycle,
// and answers once the last time has been written back.
module ordered_log_table_search #(
  parameter int DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_op,
  input  wire logic signed [47:0] in_stamp,
  input  wire logic [31:0]        in_iteration,
  input  wire logic [15:0]        in_pieces,
  input  wire logic [31:0]        in_weight,
  input  wire logic [31:0]        in_payload_handle,
  input  wire logic [31:0]        in_domain_handle,
  input  wire logic signed [47:0] in_offset,
  output logic                    out_valid,
  output logic                    out_ok,
  output logic                    out_inside_res,
  output logic [9:0]              out_entry_index,
  output logic signed [47:0]      out_stamp,
  output logic [31:0]             out_iteration,
  output logic [15:0]             out_pieces,
  output logic [31:0]             out_weight,
  output logic [31:0]             out_payload,
  output logic [31:0]             out_domain,
  output logic                    out_full_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = AW + 1;
  localparam int SW = olts_pkg::STAMP_W;
  localparam int EW = $bits(olts_pkg::entry_t);

  olts_pkg::state_t state_r, state_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [FW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [FW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic             inside_r, inside_nxt;
  logic signed [SW-1:0] q_stamp_r, q_stamp_nxt;
  logic [olts_pkg::ITER_W-1:0] q_iter_r, q_iter_nxt;
  logic signed [SW-1:0] off_r, off_nxt;
  logic signed [SW-1:0] first_time_r, first_time_nxt, last_time_r, last_time_nxt;
  logic [olts_pkg::ITER_W-1:0] first_iter_r, first_iter_nxt, last_iter_r, last_iter_nxt;
  logic             out_valid_r, out_valid_nxt;
  olts_pkg::res_t   res_r, res_nxt;

  logic             t_we, d_we;
  logic [AW-1:0]    t_waddr;
  logic [SW-1:0]    t_wdata, t_rdata;
  logic [EW-1:0]    d_rdata;
  olts_pkg::entry_t in_entry, rd_entry;
  logic signed [SW-1:0] rd_time;

  logic [FW-1:0]    addr_ext, mid_n, wr_idx;
  logic             accept, refuse_order;

  function automatic logic [FW-1:0] mid_of(input logic [FW-1:0] lo, input logic [FW-1:0] hi);
    mid_of = lo + ((hi - lo) >> 1);
  endfunction

  olts_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_time_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (addr_nxt),
    .rdata (t_rdata)
  );

  olts_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_entry),
    .raddr (addr_nxt),
    .rdata (d_rdata)
  );

  assign in_entry = '{iteration: in_iteration, pieces: in_pieces, weight: in_weight,
                      payload: in_payload_handle, domain: in_domain_handle};
  assign rd_entry = olts_pkg::entry_t'(d_rdata);
  assign rd_time  = $signed(t_rdata);
  assign addr_ext = {1'b0, addr_r};
  assign accept   = start && (state_r == olts_pkg::ST_IDLE);
  assign refuse_order = (fill_r != '0) &&
                        ((last_time_r > in_stamp) ||
                         ((in_iteration != '0) && (last_iter_r > in_iteration)));

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    cnt_nxt        = cnt_r;
    addr_nxt       = addr_r;
    inside_nxt     = inside_r;
    q_stamp_nxt    = q_stamp_r;
    q_iter_nxt     = q_iter_r;
    off_nxt        = off_r;
    first_time_nxt = first_time_r;
    last_time_nxt  = last_time_r;
    first_iter_nxt = first_iter_r;
    last_iter_nxt  = last_iter_r;
    out_valid_nxt  = 1'b0;
    res_nxt        = res_r;
    t_we           = 1'b0;
    d_we           = 1'b0;
    t_waddr        = fill_r[AW-1:0];
    t_wdata        = in_stamp;
    lo_nxt         = '0;
    hi_nxt         = '0;
    mid_n          = '0;
    wr_idx         = cnt_r - FW'(1);

    case (state_r)
      olts_pkg::ST_IDLE: begin
        if (accept) begin
          case (olts_pkg::op_t'(in_op))
            olts_pkg::OP_APPEND: begin
              out_valid_nxt = 1'b1;
              res_nxt       = '0;
              if (fill_r >= FW'(DEPTH)) begin
                res_nxt.full = 1'b1;
              end else if (!refuse_order) begin
                t_we           = 1'b1;
                d_we           = 1'b1;
                fill_nxt       = fill_r + FW'(1);
                last_time_nxt  = in_stamp;
                last_iter_nxt  = in_iteration;
                if (fill_r == '0) begin
                  first_time_nxt = in_stamp;
                  first_iter_nxt = in_iteration;
                end
                res_nxt.ok    = 1'b1;
                res_nxt.idx   = olts_pkg::IDX_W'(fill_r[AW-1:0]);
                res_nxt.stamp = in_stamp;
                res_nxt.entry = in_entry;
              end
            end
            olts_pkg::OP_FIND_TIME: begin
              q_stamp_nxt = in_stamp;
              inside_nxt  = 1'b0;
              hi_nxt      = fill_r - FW'(1);
              if (fill_r == '0) begin
                out_valid_nxt = 1'b1;
                res_nxt       = '0;
              end else if (in_stamp <= first_time_r) begin
                addr_nxt  = '0;
                state_nxt = olts_pkg::ST_TFETCH;
              end else if (in_stamp >= last_time_r) begin
                addr_nxt  = hi_nxt[AW-1:0];
                state_nxt = olts_pkg::ST_TFETCH;
              end else begin
                inside_nxt = 1'b1;
                mid_n      = mid_of('0, hi_nxt);
                if (hi_nxt > FW'(1)) begin
                  addr_nxt  = mid_n[AW-1:0];
                  state_nxt = olts_pkg::ST_TSRCH;
                end else begin
                  addr_nxt  = '0;
                  state_nxt = olts_pkg::ST_TFETCH;
                end
              end
            end
            olts_pkg::OP_FIND_ITER: begin
              q_iter_nxt = in_iteration;
              mid_n      = mid_of('0, fill_r);
              if ((fill_r == '0) || (in_iteration < first_iter_r) ||
                  (in_iteration > last_iter_r)) begin
                out_valid_nxt = 1'b1;
                res_nxt       = '0;
              end else begin
                addr_nxt  = mid_n[AW-1:0];
                lo_nxt    = '0;
                hi_nxt    = fill_r;
                state_nxt = olts_pkg::ST_ISRCH;
              end
            end
            default: begin
              off_nxt        = in_offset;
              first_time_nxt = first_time_r + in_offset;
              last_time_nxt  = last_time_r + in_offset;
              if (fill_r == '0) begin
                out_valid_nxt = 1'b1;
                res_nxt       = '0;
              end else begin
                addr_nxt  = '0;
                cnt_nxt   = FW'(1);
                state_nxt = olts_pkg::ST_SKEW;
              end
            end
          endcase
        end
      end

      // The time at addr_r is on the read port; narrow the bracket and issue
      // the next probe in the same cycle.
      olts_pkg::ST_TSRCH: begin
        lo_nxt = lo_r;
        hi_nxt = hi_r;
        if (rd_time <= q_stamp_r) begin
          lo_nxt = addr_ext;
        end else begin
          hi_nxt = addr_ext;
        end
        mid_n = mid_of(lo_nxt, hi_nxt);
        if ((hi_nxt - lo_nxt) > FW'(1)) begin
          addr_nxt = mid_n[AW-1:0];
        end else begin
          addr_nxt  = lo_nxt[AW-1:0];
          state_nxt = olts_pkg::ST_TFETCH;
        end
      end

      olts_pkg::ST_ISRCH: begin
        lo_nxt = lo_r;
        hi_nxt = hi_r;
        if (rd_entry.iteration < q_iter_r) begin
          lo_nxt = addr_ext + FW'(1);
        end else begin
          hi_nxt = addr_ext;
        end
        mid_n = mid_of(lo_nxt, hi_nxt);
        if (lo_nxt < hi_nxt) begin
          addr_nxt = mid_n[AW-1:0];
        end else if (lo_nxt < fill_r) begin
          addr_nxt  = lo_nxt[AW-1:0];
          state_nxt = olts_pkg::ST_IFETCH;
        end else begin
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          state_nxt     = olts_pkg::ST_IDLE;
        end
      end

      olts_pkg::ST_TFETCH: begin
        out_valid_nxt    = 1'b1;
        res_nxt          = '0;
        res_nxt.ok       = 1'b1;
        res_nxt.interior = inside_r;
        res_nxt.idx      = olts_pkg::IDX_W'(addr_r);
        res_nxt.stamp    = rd_time;
        res_nxt.entry    = rd_entry;
        state_nxt        = olts_pkg::ST_IDLE;
      end

      olts_pkg::ST_IFETCH: begin
        out_valid_nxt = 1'b1;
        res_nxt       = '0;
        if (rd_entry.iteration == q_iter_r) begin
          res_nxt.ok    = 1'b1;
          res_nxt.idx   = olts_pkg::IDX_W'(addr_r);
          res_nxt.stamp = rd_time;
          res_nxt.entry = rd_entry;
        end
        state_nxt = olts_pkg::ST_IDLE;
      end

      // Entry cnt_r - 1 is on the read port and goes back skewed while entry
      // cnt_r is being read, so the two addresses never meet.
      olts_pkg::ST_SKEW: begin
        t_we    = 1'b1;
        t_waddr = wr_idx[AW-1:0];
        t_wdata = rd_time + off_r;
        if (cnt_r < fill_r) begin
          addr_nxt = cnt_r[AW-1:0];
          cnt_nxt  = cnt_r + FW'(1);
        end else begin
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          state_nxt     = olts_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = olts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olts_pkg::ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    cnt_r        <= cnt_nxt;
    inside_r     <= inside_nxt;
    q_stamp_r    <= q_stamp_nxt;
    q_iter_r     <= q_iter_nxt;
    off_r        <= off_nxt;
    first_time_r <= first_time_nxt;
    last_time_r  <= last_time_nxt;
    first_iter_r <= first_iter_nxt;
    last_iter_r  <= last_iter_nxt;
    res_r        <= res_nxt;
  end

  assign busy            = (state_r != olts_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_ok          = res_r.ok;
  assign out_inside_res  = res_r.interior;
  assign out_entry_index = res_r.idx;
  assign out_stamp       = res_r.stamp;
  assign out_iteration   = res_r.entry.iteration;
  assign out_pieces      = res_r.entry.pieces;
  assign out_weight      = res_r.entry.weight;
  assign out_payload     = res_r.entry.payload;
  assign out_domain      = res_r.entry.domain;
  assign out_full_res    = res_r.full;

  // A result word is only ever shown once the controller is back in idle.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid_r |-> !busy)
    else $error("result word shown while busy");

  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= FW'(DEPTH))
    else $error("fill count beyond table depth");

  // An append grows the table exactly when its result reports success.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (accept && (in_op == olts_pkg::OP_APPEND)) |=>
                   (out_valid_r && (res_r.ok == (fill_r != $past(fill_r)))))
    else $error("append result disagrees with fill count");

  // Only a skew writes the time memory outside idle.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (t_we && (state_r != olts_pkg::ST_IDLE)) |-> (state_r == olts_pkg::ST_SKEW))
    else $error("time memory written outside a skew pass");

endmodule
`default_nettype wire
